### rtl/core/wda_pkg.sv
// ----------------------------------------------------------------------------
// wda_pkg
// Shared types, constants and saturating helpers of the word discrepancy
// accumulator.
// ----------------------------------------------------------------------------
package wda_pkg;

    localparam int N_W     = 20;
    localparam int L_W     = 24;
    localparam int P_W     = 32;
    localparam int EPS_W   = 16;
    localparam int X_W     = 41;
    localparam int MAG_W   = 42;
    localparam int MB_W    = 48;
    localparam int CHUNK_W = 16;
    localparam int MP_W    = 90;
    localparam int Q_W     = 63;
    localparam int LOG_W   = 30;
    localparam int LN_W    = 23;
    localparam int IDX_W   = 3;
    localparam int CFG_W   = 32;
    localparam int IN_W    = 80;
    localparam int OUT_W   = 384;

    localparam logic [62:0] U63_MAX = {63{1'b1}};
    localparam logic [63:0] S64_MAX = {1'b0, {63{1'b1}}};
    localparam logic [63:0] S64_MIN = {1'b1, 63'd0};
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;

    typedef enum logic [2:0] {
        CFG_FLOOR_EPS = 3'd0,
        CFG_BASE_PROB = 3'd1,
        CFG_MODEL_EN  = 3'd2,
        CFG_NULL_EN   = 3'd3,
        CFG_SQ_EN     = 3'd4,
        CFG_PE_EN     = 3'd5,
        CFG_DEV_EN    = 3'd6
    } t_cfg_idx;

    typedef enum logic [3:0] {
        OP_NONE, OP_MUL_EXP, OP_EXP, OP_MUL_SQ, OP_SQ_ACC, OP_MUL_PE, OP_DIV,
        OP_PE_ACC, OP_LOG_N, OP_LOG_X, OP_MUL_LN, OP_MUL_DV, OP_DV_ACC,
        OP_LIN_ACC, OP_EMIT
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE, ST_WAIT, ST_EXP_MUL, ST_EXP, ST_SQ_MUL, ST_SQ_ACC, ST_PE_MUL,
        ST_DIV, ST_PE_ACC, ST_LOG_N, ST_LOG_X, ST_LN_MUL, ST_DV_MUL, ST_DV_ACC,
        ST_LIN, ST_FIN
    } t_state;

    typedef struct packed {
        t_op  op;
        logic side;
        logic in_ready;
    } t_cmd;

    typedef struct packed {
        logic busy;
        logic last;
        logic n_nz;
        logic out_full;
        logic model_en;
        logic null_en;
        logic sq_en;
        logic pe_en;
        logic dv_en;
    } t_status;

    function automatic logic [62:0] f_sat_add_u63(input logic [62:0] a,
                                                  input logic [62:0] b);
        logic [63:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[63] ? U63_MAX : s[62:0];
    endfunction

    function automatic logic [63:0] f_sat_add_s64(input logic [63:0] a,
                                                  input logic [63:0] b);
        logic [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            return s[64] ? S64_MIN : S64_MAX;
        end
        return s[63:0];
    endfunction

    function automatic logic [63:0] f_clamp_s64(input logic [66:0] v);
        if (v[66:63] == 4'b0000 || v[66:63] == 4'b1111) begin
            return v[63:0];
        end
        return v[66] ? S64_MIN : S64_MAX;
    endfunction

endpackage

### rtl/core/word_discrepancy_accumulator.sv
// ----------------------------------------------------------------------------
// word_discrepancy_accumulator
// Per-word squared error, Pearson chi-square and Poisson deviance indices.
// ----------------------------------------------------------------------------
// One document item at a time. Per enabled side an item runs a chunked
// multiply for the expectation, another for the squared error, one more
// plus a bit-serial divider for Pearson, and for deviance two log2 passes
// (a serial normalize of a 42-bit word plus 24 squaring steps each) and two
// multiplies. An item with all sides disabled goes straight to the finish
// state. The result of the last item sits in an output register, so the
// next stream starts while it waits to be taken.
// ----------------------------------------------------------------------------
module word_discrepancy_accumulator (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    // obs_count[19:0], doc_length[43:20], fitted_prob[75:44], zero pad
    input  logic [wda_pkg::IN_W-1:0]  i_s_tdata,
    input  logic                      i_s_tlast,
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    // sq_err_model[62:0], sq_err_null[125:63], pearson_model[188:126],
    // pearson_null[251:189], deviance_model[315:252], deviance_null[379:316]
    output logic [wda_pkg::OUT_W-1:0] o_m_tdata,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [wda_pkg::IDX_W-1:0] i_cfg_index,
    input  logic [wda_pkg::CFG_W-1:0] i_cfg_data
);

    wda_pkg::t_cmd    cmd;
    wda_pkg::t_status status;

    wda_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    wda_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_s_tvalid  (i_s_tvalid),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    assign o_s_tready  = cmd.in_ready;
    assign o_cfg_ready = 1'b1;

endmodule

### rtl/core/wda_div.sv
// ----------------------------------------------------------------------------
// wda_div
// Restoring divider, one quotient bit per cycle, 63-bit saturating quotient.
// ----------------------------------------------------------------------------
module wda_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [wda_pkg::MP_W-1:0]  i_dividend,
    input  logic [wda_pkg::MAG_W-1:0] i_divisor,
    output logic                      o_busy,
    output logic [wda_pkg::Q_W-1:0]   o_quot
);

    logic                      r_busy;
    logic                      r_sat;
    logic [wda_pkg::MAG_W-1:0] r_rem;
    logic [wda_pkg::MAG_W-1:0] r_div;
    logic [wda_pkg::Q_W-1:0]   r_low;
    logic [wda_pkg::Q_W-1:0]   r_q;
    logic [5:0]                r_cnt;

    logic [wda_pkg::MAG_W-1:0] hi_ext;
    logic                      start_sat;
    logic [wda_pkg::MAG_W-1:0] trial;
    logic                      ge;

    assign hi_ext    = {15'd0, i_dividend[wda_pkg::MP_W-1:wda_pkg::Q_W]};
    assign start_sat = hi_ext >= i_divisor;
    assign trial     = {r_rem[wda_pkg::MAG_W-2:0], r_low[wda_pkg::Q_W-1]};
    assign ge        = trial >= r_div;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= !start_sat;
        end else if (r_busy && r_cnt == 6'(wda_pkg::Q_W - 1)) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sat <= start_sat;
            r_rem <= hi_ext;
            r_div <= i_divisor;
            r_low <= i_dividend[wda_pkg::Q_W-1:0];
            r_q   <= '0;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? trial - r_div : trial;
            r_low <= {r_low[wda_pkg::Q_W-2:0], 1'b0};
            r_q   <= {r_q[wda_pkg::Q_W-2:0], ge};
            r_cnt <= r_cnt + 6'd1;
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_sat ? wda_pkg::U63_MAX : r_q;

endmodule

### rtl/core/wda_log2.sv
// ----------------------------------------------------------------------------
// wda_log2
// Base-2 logarithm, Q.24: serial normalize, then 24 mantissa squarings.
// ----------------------------------------------------------------------------
module wda_log2 (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [wda_pkg::MAG_W-1:0] i_value,
    output logic                      o_busy,
    output logic [wda_pkg::LOG_W-1:0] o_log
);

    logic                      r_norm;
    logic                      r_sq;
    logic [wda_pkg::MAG_W-1:0] r_v;
    logic [5:0]                r_k;
    logic [30:0]               r_m;
    logic [23:0]               r_f;
    logic [4:0]                r_cnt;

    logic [61:0] sq;
    logic [31:0] t;

    assign sq = r_m * r_m;
    assign t  = sq[61:30];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_norm <= 1'b0;
            r_sq   <= 1'b0;
        end else if (i_start) begin
            r_norm <= 1'b1;
            r_sq   <= 1'b0;
        end else if (r_norm && r_v[wda_pkg::MAG_W-1]) begin
            r_norm <= 1'b0;
            r_sq   <= 1'b1;
        end else if (r_sq && r_cnt == 5'd23) begin
            r_sq <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v <= i_value;
            r_k <= 6'(wda_pkg::MAG_W - 1);
            r_f <= '0;
        end else if (r_norm) begin
            if (r_v[wda_pkg::MAG_W-1]) begin
                r_m   <= r_v[wda_pkg::MAG_W-1:11];
                r_cnt <= '0;
            end else begin
                r_v <= {r_v[wda_pkg::MAG_W-2:0], 1'b0};
                r_k <= r_k - 6'd1;
            end
        end else if (r_sq) begin
            r_m   <= t[31] ? t[31:1] : t[30:0];
            r_f   <= {r_f[22:0], t[31]};
            r_cnt <= r_cnt + 5'd1;
        end
    end

    assign o_busy = r_norm | r_sq;
    assign o_log  = {r_k, r_f};

endmodule

### rtl/core/wda_dp.sv
// ----------------------------------------------------------------------------
// wda_dp
// Datapath: config registers, item latch, shared chunked multiplier,
// divider, log unit, accumulators and output register.
// ----------------------------------------------------------------------------
module wda_dp (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  wda_pkg::t_cmd             i_cmd,
    output wda_pkg::t_status          o_status,
    input  logic                      i_s_tvalid,
    input  logic [wda_pkg::IN_W-1:0]  i_s_tdata,
    input  logic                      i_s_tlast,
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    output logic [wda_pkg::OUT_W-1:0] o_m_tdata,
    input  logic                      i_cfg_valid,
    input  logic [wda_pkg::IDX_W-1:0] i_cfg_index,
    input  logic [wda_pkg::CFG_W-1:0] i_cfg_data
);

    // config
    logic [wda_pkg::EPS_W-1:0] r_eps;
    logic [wda_pkg::P_W-1:0]   r_bp;
    logic r_model_en, r_null_en, r_sq_en, r_pe_en, r_dv_en;

    // item
    logic [wda_pkg::N_W-1:0] r_n;
    logic [wda_pkg::L_W-1:0] r_len;
    logic [wda_pkg::P_W-1:0] r_prob;
    logic                    r_last;

    // working
    logic [wda_pkg::X_W-1:0]   r_x;
    logic [wda_pkg::LOG_W-1:0] r_lgn;
    logic                      r_neg;

    // multiplier
    logic                      r_mul_busy;
    logic [1:0]                r_mul_cnt;
    logic [wda_pkg::MAG_W-1:0] r_mul_a;
    logic [wda_pkg::MB_W-1:0]  r_mul_b;
    logic [wda_pkg::MP_W-1:0]  r_mul_p;

    // accumulators
    logic [62:0] r_acc_sq [2];
    logic [62:0] r_acc_pe [2];
    logic [63:0] r_acc_dv [2];
    logic [63:0] r_acc_lin;

    // output
    logic        r_out_valid;
    logic [62:0] r_out_sqm, r_out_sqn, r_out_pem, r_out_pen;
    logic [63:0] r_out_dvm, r_out_dvn;

    logic                      accept;
    logic [wda_pkg::X_W-1:0]   eps_x;
    logic [wda_pkg::X_W-1:0]   n16;
    logic [wda_pkg::X_W-1:0]   xf;
    logic [wda_pkg::MAG_W-1:0] mag_x;
    logic [wda_pkg::MAG_W-1:0] mag_xf;
    logic [31:0]               diff;
    logic [31:0]               diff_abs;
    logic [62:0]               ln_sum;
    logic [wda_pkg::LN_W-1:0]  ln16;
    logic [56:0]               x_sum;
    logic [62:0]               sq_term;
    logic [63:0]               dv_mag;
    logic [63:0]               dv_term;
    logic [41:0]               lin_d;
    logic [63:0]               lin_term;
    logic [57:0]               part;
    logic [wda_pkg::MP_W-1:0]  part_sh;
    logic                      mul_start;
    logic [wda_pkg::MAG_W-1:0] mul_a_in;
    logic [wda_pkg::MB_W-1:0]  mul_b_in;
    logic                      div_start;
    logic                      div_busy;
    logic [wda_pkg::Q_W-1:0]   div_quot;
    logic                      log_start;
    logic                      log_busy;
    logic [wda_pkg::MAG_W-1:0] log_in;
    logic [wda_pkg::LOG_W-1:0] log_out;
    logic [66:0]               dvm_wide;
    logic [66:0]               dvn_wide;
    logic                      sd;

    assign accept = i_s_tvalid && i_cmd.in_ready;
    assign sd     = i_cmd.side;

    assign eps_x    = (r_eps == '0) ? 41'd1 : {25'd0, r_eps};
    assign n16      = {5'd0, r_n, 16'd0};
    assign xf       = (r_x < eps_x) ? eps_x : r_x;
    assign mag_x    = (n16 >= r_x) ? {1'b0, n16 - r_x} : {1'b0, r_x - n16};
    assign mag_xf   = (n16 >= xf) ? {1'b0, n16 - xf} : {1'b0, xf - n16};
    assign diff     = {2'd0, r_lgn} - {2'd0, log_out} + 32'h1000_0000;
    assign diff_abs = diff[31] ? (32'd0 - diff) : diff;
    assign ln_sum   = {1'b0, r_mul_p[61:0]} + (63'd1 << 39);
    assign ln16     = ln_sum[62:40];
    assign x_sum    = {1'b0, r_mul_p[55:0]} + 57'd16384;
    assign sq_term  = (r_mul_p[89:71] != '0) ? wda_pkg::U63_MAX : r_mul_p[70:8];
    assign dv_mag   = {13'd0, r_mul_p[42:0], 8'd0};
    assign dv_term  = r_neg ? (64'd0 - dv_mag) : dv_mag;
    assign lin_d    = {1'b0, n16} - {1'b0, r_x};
    assign lin_term = {{14{lin_d[41]}}, lin_d, 8'd0};

    assign part    = r_mul_a * r_mul_b[wda_pkg::CHUNK_W-1:0];
    assign part_sh = {32'd0, part} << {r_mul_cnt, 4'd0};

    always_comb begin
        mul_start = 1'b1;
        mul_a_in  = mag_x;
        mul_b_in  = {6'd0, mag_x};
        case (i_cmd.op)
            wda_pkg::OP_MUL_EXP: begin
                mul_a_in = {10'd0, sd ? r_bp : r_prob};
                mul_b_in = {24'd0, r_len};
            end
            wda_pkg::OP_MUL_SQ: begin
                mul_a_in = mag_x;
                mul_b_in = {6'd0, mag_x};
            end
            wda_pkg::OP_MUL_PE: begin
                mul_a_in = mag_xf;
                mul_b_in = {6'd0, mag_xf};
            end
            wda_pkg::OP_MUL_LN: begin
                mul_a_in = {12'd0, diff_abs[29:0]};
                mul_b_in = {16'd0, wda_pkg::LN2_Q32};
            end
            wda_pkg::OP_MUL_DV: begin
                mul_a_in = {22'd0, r_n};
                mul_b_in = {25'd0, ln16};
            end
            default: mul_start = 1'b0;
        endcase
    end

    assign div_start = i_cmd.op == wda_pkg::OP_DIV;
    assign log_start = i_cmd.op == wda_pkg::OP_LOG_N || i_cmd.op == wda_pkg::OP_LOG_X;
    assign log_in    = (i_cmd.op == wda_pkg::OP_LOG_N) ? {22'd0, r_n} : {1'b0, xf};

    wda_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ({r_mul_p[81:0], 8'd0}),
        .i_divisor  ({1'b0, xf}),
        .o_busy     (div_busy),
        .o_quot     (div_quot)
    );

    wda_log2 u_log2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (log_start),
        .i_value (log_in),
        .o_busy  (log_busy),
        .o_log   (log_out)
    );

    assign dvm_wide = ({{3{r_acc_dv[0][63]}}, r_acc_dv[0]}
                     - {{3{r_acc_lin[63]}}, r_acc_lin}) << 1;
    assign dvn_wide = {{3{r_acc_dv[1][63]}}, r_acc_dv[1]} << 1;

    // config port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps      <= 16'd1;
            r_bp       <= '0;
            r_model_en <= 1'b1;
            r_null_en  <= 1'b1;
            r_sq_en    <= 1'b1;
            r_pe_en    <= 1'b1;
            r_dv_en    <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                wda_pkg::CFG_FLOOR_EPS: r_eps      <= i_cfg_data[wda_pkg::EPS_W-1:0];
                wda_pkg::CFG_BASE_PROB: r_bp       <= i_cfg_data;
                wda_pkg::CFG_MODEL_EN:  r_model_en <= i_cfg_data[0];
                wda_pkg::CFG_NULL_EN:   r_null_en  <= i_cfg_data[0];
                wda_pkg::CFG_SQ_EN:     r_sq_en    <= i_cfg_data[0];
                wda_pkg::CFG_PE_EN:     r_pe_en    <= i_cfg_data[0];
                wda_pkg::CFG_DEV_EN:    r_dv_en    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // item latch and working registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_n    <= i_s_tdata[19:0];
            r_len  <= i_s_tdata[43:20];
            r_prob <= i_s_tdata[75:44];
            r_last <= i_s_tlast;
        end
        if (i_cmd.op == wda_pkg::OP_EXP) begin
            r_x <= x_sum[55:15];
        end
        if (i_cmd.op == wda_pkg::OP_LOG_X) begin
            r_lgn <= log_out;
        end
        if (i_cmd.op == wda_pkg::OP_MUL_LN) begin
            r_neg <= diff[31];
        end
    end

    // multiplier: three 16-bit chunks of b
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_busy <= 1'b0;
        end else if (mul_start) begin
            r_mul_busy <= 1'b1;
        end else if (r_mul_busy && r_mul_cnt == 2'd2) begin
            r_mul_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mul_start) begin
            r_mul_a   <= mul_a_in;
            r_mul_b   <= mul_b_in;
            r_mul_p   <= '0;
            r_mul_cnt <= '0;
        end else if (r_mul_busy) begin
            r_mul_p   <= r_mul_p + part_sh;
            r_mul_b   <= {16'd0, r_mul_b[wda_pkg::MB_W-1:wda_pkg::CHUNK_W]};
            r_mul_cnt <= r_mul_cnt + 2'd1;
        end
    end

    // accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.op == wda_pkg::OP_EMIT) begin
            r_acc_sq[0] <= '0;
            r_acc_sq[1] <= '0;
            r_acc_pe[0] <= '0;
            r_acc_pe[1] <= '0;
            r_acc_dv[0] <= '0;
            r_acc_dv[1] <= '0;
            r_acc_lin   <= '0;
        end else begin
            case (i_cmd.op)
                wda_pkg::OP_SQ_ACC:  r_acc_sq[sd] <= wda_pkg::f_sat_add_u63(r_acc_sq[sd], sq_term);
                wda_pkg::OP_PE_ACC:  r_acc_pe[sd] <= wda_pkg::f_sat_add_u63(r_acc_pe[sd], div_quot);
                wda_pkg::OP_DV_ACC:  r_acc_dv[sd] <= wda_pkg::f_sat_add_s64(r_acc_dv[sd], dv_term);
                wda_pkg::OP_LIN_ACC: r_acc_lin    <= wda_pkg::f_sat_add_s64(r_acc_lin, lin_term);
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == wda_pkg::OP_EMIT) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == wda_pkg::OP_EMIT) begin
            r_out_sqm <= r_acc_sq[0];
            r_out_sqn <= r_acc_sq[1];
            r_out_pem <= r_acc_pe[0];
            r_out_pen <= r_acc_pe[1];
            r_out_dvm <= wda_pkg::f_clamp_s64(dvm_wide);
            r_out_dvn <= wda_pkg::f_clamp_s64(dvn_wide);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'd0, r_out_dvn, r_out_dvm, r_out_pen, r_out_pem,
                         r_out_sqn, r_out_sqm};

    assign o_status.busy     = r_mul_busy | div_busy | log_busy;
    assign o_status.last     = r_last;
    assign o_status.n_nz     = r_n != '0;
    assign o_status.out_full = r_out_valid;
    assign o_status.model_en = r_model_en;
    assign o_status.null_en  = r_null_en;
    assign o_status.sq_en    = r_sq_en;
    assign o_status.pe_en    = r_pe_en;
    assign o_status.dv_en    = r_dv_en;

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == wda_pkg::OP_EMIT |-> !r_out_valid)
        else $error("emit while output register full");

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mul_start || div_start || log_start) |-> !o_status.busy)
        else $error("unit started while another is busy");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == wda_pkg::OP_EMIT |=>
            (r_acc_lin == '0 && r_acc_dv[0] == '0 && r_acc_sq[0] == '0))
        else $error("accumulators not cleared after emit");

endmodule

### rtl/core/wda_ctrl.sv
// ----------------------------------------------------------------------------
// wda_ctrl
// Sequencer: walks each enabled side and family through the datapath units.
// ----------------------------------------------------------------------------
module wda_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    input  wda_pkg::t_status i_status,
    output wda_pkg::t_cmd    o_cmd
);

    wda_pkg::t_state r_state, n_state;
    wda_pkg::t_state r_ret, n_ret;
    logic            r_side, n_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wda_pkg::ST_IDLE;
            r_ret   <= wda_pkg::ST_IDLE;
            r_side  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_side  <= n_side;
        end
    end

    always_comb begin
        wda_pkg::t_state nx_side, nx_lin, nx_dv, nx_pe, nx_sq;
        nx_side = (!r_side && i_status.null_en) ? wda_pkg::ST_EXP_MUL : wda_pkg::ST_FIN;
        nx_lin  = (!r_side && i_status.dv_en) ? wda_pkg::ST_LIN : nx_side;
        nx_dv   = (i_status.dv_en && i_status.n_nz) ? wda_pkg::ST_LOG_N : nx_lin;
        nx_pe   = i_status.pe_en ? wda_pkg::ST_PE_MUL : nx_dv;
        nx_sq   = i_status.sq_en ? wda_pkg::ST_SQ_MUL : nx_pe;
        n_state = r_state;
        n_ret   = r_ret;
        n_side  = r_side;
        case (r_state)
            wda_pkg::ST_IDLE: begin
                if (i_s_tvalid) begin
                    if (i_status.model_en) begin
                        n_state = wda_pkg::ST_EXP_MUL;
                        n_side  = 1'b0;
                    end else if (i_status.null_en) begin
                        n_state = wda_pkg::ST_EXP_MUL;
                        n_side  = 1'b1;
                    end else begin
                        n_state = wda_pkg::ST_FIN;
                    end
                end
            end
            wda_pkg::ST_WAIT: begin
                if (!i_status.busy) n_state = r_ret;
            end
            wda_pkg::ST_EXP_MUL: begin
                n_state = wda_pkg::ST_WAIT;
                n_ret   = wda_pkg::ST_EXP;
            end
            wda_pkg::ST_EXP:    n_state = nx_sq;
            wda_pkg::ST_SQ_MUL: begin
                n_state = wda_pkg::ST_WAIT;
                n_ret   = wda_pkg::ST_SQ_ACC;
            end
            wda_pkg::ST_SQ_ACC: n_state = nx_pe;
            wda_pkg::ST_PE_MUL: begin
                n_state = wda_pkg::ST_WAIT;
                n_ret   = wda_pkg::ST_DIV;
            end
            wda_pkg::ST_DIV: begin
                n_state = wda_pkg::ST_WAIT;
                n_ret   = wda_pkg::ST_PE_ACC;
            end
            wda_pkg::ST_PE_ACC: n_state = nx_dv;
            wda_pkg::ST_LOG_N: begin
                n_state = wda_pkg::ST_WAIT;
                n_ret   = wda_pkg::ST_LOG_X;
            end
            wda_pkg::ST_LOG_X: begin
                n_state = wda_pkg::ST_WAIT;
                n_ret   = wda_pkg::ST_LN_MUL;
            end
            wda_pkg::ST_LN_MUL: begin
                n_state = wda_pkg::ST_WAIT;
                n_ret   = wda_pkg::ST_DV_MUL;
            end
            wda_pkg::ST_DV_MUL: begin
                n_state = wda_pkg::ST_WAIT;
                n_ret   = wda_pkg::ST_DV_ACC;
            end
            wda_pkg::ST_DV_ACC: n_state = nx_lin;
            wda_pkg::ST_LIN:    n_state = nx_side;
            wda_pkg::ST_FIN: begin
                if (!i_status.last || !i_status.out_full) n_state = wda_pkg::ST_IDLE;
            end
            default: n_state = wda_pkg::ST_IDLE;
        endcase
        // model side done, move to null side
        if (r_state != wda_pkg::ST_IDLE && n_state == wda_pkg::ST_EXP_MUL) begin
            n_side = 1'b1;
        end
    end

    always_comb begin
        o_cmd.side     = r_side;
        o_cmd.in_ready = r_state == wda_pkg::ST_IDLE;
        case (r_state)
            wda_pkg::ST_EXP_MUL: o_cmd.op = wda_pkg::OP_MUL_EXP;
            wda_pkg::ST_EXP:     o_cmd.op = wda_pkg::OP_EXP;
            wda_pkg::ST_SQ_MUL:  o_cmd.op = wda_pkg::OP_MUL_SQ;
            wda_pkg::ST_SQ_ACC:  o_cmd.op = wda_pkg::OP_SQ_ACC;
            wda_pkg::ST_PE_MUL:  o_cmd.op = wda_pkg::OP_MUL_PE;
            wda_pkg::ST_DIV:     o_cmd.op = wda_pkg::OP_DIV;
            wda_pkg::ST_PE_ACC:  o_cmd.op = wda_pkg::OP_PE_ACC;
            wda_pkg::ST_LOG_N:   o_cmd.op = wda_pkg::OP_LOG_N;
            wda_pkg::ST_LOG_X:   o_cmd.op = wda_pkg::OP_LOG_X;
            wda_pkg::ST_LN_MUL:  o_cmd.op = wda_pkg::OP_MUL_LN;
            wda_pkg::ST_DV_MUL:  o_cmd.op = wda_pkg::OP_MUL_DV;
            wda_pkg::ST_DV_ACC:  o_cmd.op = wda_pkg::OP_DV_ACC;
            wda_pkg::ST_LIN:     o_cmd.op = wda_pkg::OP_LIN_ACC;
            wda_pkg::ST_FIN: begin
                o_cmd.op = (i_status.last && !i_status.out_full) ?
                           wda_pkg::OP_EMIT : wda_pkg::OP_NONE;
            end
            default:             o_cmd.op = wda_pkg::OP_NONE;
        endcase
    end

endmodule

### test/tb_word_discrepancy_accumulator.sv
// ----------------------------------------------------------------------------
// tb_word_discrepancy_accumulator
// Self-checking bench for the word discrepancy accumulator. A directed list of
// documents and register writes comes first, then random document streams
// under a series of register settings. Every result is checked field by field
// against a fixed-point predictor of the six indices, or a typed row's value.
// ----------------------------------------------------------------------------
module tb_word_discrepancy_accumulator;

    localparam int          CYCLE_LIMIT = 6000000;
    localparam int          SETTLE      = 600;
    localparam int          N_PHASES    = 11;
    localparam int          PHASE_ITEMS = 150;
    localparam int          QUIET_ITEMS = 150;
    localparam logic [2:0]  CFG_UNUSED  = 3'd7;
    localparam logic [63:0] LN2         = 64'd2977044472;

    typedef struct packed {
        logic [62:0] sq_model;
        logic [62:0] sq_null;
        logic [62:0] pe_model;
        logic [62:0] pe_null;
        logic [63:0] dv_model;
        logic [63:0] dv_null;
    } t_indices;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic [2:0]  idx;
        logic [31:0] val;
        logic [19:0] n;
        logic [23:0] len;
        logic [31:0] p;
        logic        last;
        logic        typed;
        t_indices    res;
    } t_row;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_s_tvalid;
    logic                         o_s_tready;
    logic [wda_pkg::IN_W-1:0]     i_s_tdata;
    logic                         i_s_tlast;
    logic                         o_m_tvalid;
    logic                         i_m_tready;
    logic [wda_pkg::OUT_W-1:0]    o_m_tdata;
    logic                         i_cfg_valid;
    logic                         o_cfg_ready;
    logic [wda_pkg::IDX_W-1:0]    i_cfg_index;
    logic [wda_pkg::CFG_W-1:0]    i_cfg_data;

    word_discrepancy_accumulator uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // predictor copy of registers and accumulators
    logic [15:0]        m_floor;
    logic [31:0]        m_base;
    logic               m_model_en, m_null_en, m_sq_en, m_pe_en, m_dv_en;
    logic [62:0]        a_sq_model, a_sq_null, a_pe_model, a_pe_null;
    logic signed [63:0] a_dv_model, a_dv_null, a_lin;

    t_indices pending_indices[$];
    int       errors;
    int       cycles;
    logic     quiet;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic [62:0] add_u63(logic [62:0] a, logic [62:0] b);
        logic [63:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[63] ? {63{1'b1}} : s[62:0];
    endfunction

    function automatic logic signed [63:0] add_s64(logic signed [63:0] a,
                                                   logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) return s[64] ? wda_pkg::S64_MIN : wda_pkg::S64_MAX;
        return s[63:0];
    endfunction

    function automatic logic [62:0] sq_contrib(logic [63:0] mag);
        logic [127:0] pr;
        pr = {64'd0, mag} * {64'd0, mag};
        if (pr[127:71] != 0) return {63{1'b1}};
        return pr[70:8];
    endfunction

    function automatic logic [62:0] pe_contrib(logic [63:0] mag, logic [63:0] div);
        logic [127:0] num;
        logic [127:0] q;
        num = {64'd0, mag} * {64'd0, mag};
        num = num << 8;
        q = num / {64'd0, div};
        if (q[127:63] != 0) return {63{1'b1}};
        return q[62:0];
    endfunction

    function automatic logic [63:0] log2_fx(logic [63:0] v);
        int          k;
        logic [63:0] m;
        logic [63:0] f;
        k = 63;
        f = 0;
        while (k > 0 && !v[k]) k--;
        m = (k <= 30) ? (v << (30 - k)) : (v >> (k - 30));
        for (int i = 23; i >= 0; i--) begin
            m = (m * m) >> 30;
            if (m >= 64'h8000_0000) begin
                f[i] = 1'b1;
                m = m >> 1;
            end
        end
        return (64'(k) << 24) | f;
    endfunction

    function automatic logic signed [63:0] dv_contrib(logic [63:0] n, logic [63:0] xf);
        logic signed [63:0] diff;
        logic [63:0]        mag;
        logic signed [63:0] ln16;
        diff = $signed(log2_fx(n)) - $signed(log2_fx(xf)) + 64'sd268435456;
        mag = diff < 0 ? 64'(-diff) : 64'(diff);
        ln16 = $signed((mag * LN2 + (64'd1 << 39)) >> 40);
        if (diff < 0) ln16 = -ln16;
        return $signed(n) * ln16 * 64'sd256;
    endfunction

    function automatic void side_update(input logic [63:0] n, input logic [63:0] x,
                                        inout logic [62:0] sq, inout logic [62:0] pe,
                                        inout logic signed [63:0] dv);
        logic [63:0] eps, n16, xf;
        eps = (m_floor == 0) ? 64'd1 : 64'(m_floor);
        n16 = n << 16;
        xf = (x < eps) ? eps : x;
        if (m_sq_en) sq = add_u63(sq, sq_contrib(n16 >= x ? n16 - x : x - n16));
        if (m_pe_en) pe = add_u63(pe, pe_contrib(n16 >= xf ? n16 - xf : xf - n16, xf));
        if (m_dv_en && n != 0) dv = add_s64(dv, dv_contrib(n, xf));
    endfunction

    // returns 1 and fills res when the document closes a stream
    function automatic logic predict_indices(logic [19:0] n, logic [23:0] len,
                                             logic [31:0] p, logic last,
                                             output t_indices res);
        logic [63:0]        e, b;
        logic signed [63:0] d;
        res = '0;
        if (m_model_en) begin
            e = (64'(len) * 64'(p) + (64'd1 << 14)) >> 15;
            side_update(64'(n), e, a_sq_model, a_pe_model, a_dv_model);
            if (m_dv_en)
                a_lin = add_s64(a_lin, ($signed(64'(n) << 16) - $signed(e)) * 64'sd256);
        end
        if (m_null_en) begin
            b = (64'(len) * 64'(m_base) + (64'd1 << 14)) >> 15;
            side_update(64'(n), b, a_sq_null, a_pe_null, a_dv_null);
        end
        if (!last) return 1'b0;
        res.sq_model = a_sq_model;
        res.sq_null  = a_sq_null;
        res.pe_model = a_pe_model;
        res.pe_null  = a_pe_null;
        if (a_lin == $signed(wda_pkg::S64_MIN))
            d = add_s64(add_s64(a_dv_model, wda_pkg::S64_MAX), 64'sd1);
        else d = add_s64(a_dv_model, -a_lin);
        res.dv_model = add_s64(d, d);
        res.dv_null  = add_s64(a_dv_null, a_dv_null);
        a_sq_model = 0; a_sq_null = 0; a_pe_model = 0; a_pe_null = 0;
        a_dv_model = 0; a_dv_null = 0; a_lin = 0;
        return 1'b1;
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            wda_pkg::CFG_FLOOR_EPS: m_floor    = val[15:0];
            wda_pkg::CFG_BASE_PROB: m_base     = val;
            wda_pkg::CFG_MODEL_EN:  m_model_en = val[0];
            wda_pkg::CFG_NULL_EN:   m_null_en  = val[0];
            wda_pkg::CFG_SQ_EN:     m_sq_en    = val[0];
            wda_pkg::CFG_PE_EN:     m_pe_en    = val[0];
            wda_pkg::CFG_DEV_EN:    m_dv_en    = val[0];
            default: ;
        endcase
    endtask

    // hold off until every result is back, then let the block run dry
    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (pending_indices.size() > 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic send_doc(input logic [19:0] n, input logic [23:0] len,
                            input logic [31:0] p, input logic last,
                            input logic typed, input t_indices typed_res);
        t_indices res;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {4'd0, p, len, n};
        i_s_tlast  <= last;
        do @(posedge i_clk); while (!o_s_tready);
        if (predict_indices(n, len, p, last, res))
            pending_indices.push_back(typed ? typed_res : res);
    endtask

    task automatic sender_gap();
        if (!quiet && $urandom_range(0, 4) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
    endtask

    task automatic cmp_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_indices want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_indices.size() == 0) begin
                $error("result with no document stream closed");
                errors++;
            end else begin
                want = pending_indices.pop_front();
                cmp_field("sq_err_model",   64'(want.sq_model), 64'(o_m_tdata[62:0]));
                cmp_field("sq_err_null",    64'(want.sq_null),  64'(o_m_tdata[125:63]));
                cmp_field("pearson_model",  64'(want.pe_model), 64'(o_m_tdata[188:126]));
                cmp_field("pearson_null",   64'(want.pe_null),  64'(o_m_tdata[251:189]));
                cmp_field("deviance_model", want.dv_model,      o_m_tdata[315:252]);
                cmp_field("deviance_null",  want.dv_null,       o_m_tdata[379:316]);
            end
        end
    end

    initial begin
        i_m_tready = 1'b0;
        @(posedge i_clk);
        forever begin
            if (quiet) begin
                i_m_tready <= 1'b1;
                @(posedge i_clk);
            end else if ($urandom_range(0, 2) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
            end else begin
                i_m_tready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge i_clk);
            end
        end
    end

    function automatic t_row row_doc(logic [19:0] n, logic [23:0] len, logic [31:0] p,
                                     logic last);
        t_row r;
        r = '{ROW_ITEM, wda_pkg::CFG_FLOOR_EPS, 32'd0, n, len, p, last, 1'b0, '0};
        return r;
    endfunction

    function automatic t_row row_reg(logic [2:0] idx, logic [31:0] val);
        t_row r;
        r = '{ROW_CFG, idx, val, 20'd0, 24'd0, 32'd0, 1'b0, 1'b0, '0};
        return r;
    endfunction

    function automatic logic [19:0] rand_count();
        case ($urandom_range(0, 7))
            0:       return 20'd0;
            1:       return 20'($urandom);
            2:       return 20'hFFFFF;
            default: return 20'($urandom_range(0, 40));
        endcase
    endfunction

    function automatic logic [31:0] rand_prob();
        case ($urandom_range(0, 7))
            0:       return 32'($urandom);
            1:       return 32'h8000_0000;
            2:       return 32'd0;
            default: return 32'($urandom_range(0, 32'h0400_0000));
        endcase
    endfunction

    initial begin
        t_row     rows[$];
        t_row     r;
        int       left;
        int       total;
        t_indices zero_res;
        t_indices floor_res;

        errors = 0; cycles = 0; quiet = 1'b0;
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0; i_s_tdata = '0; i_s_tlast = 1'b0;
        i_cfg_valid = 1'b0; i_cfg_index = '0; i_cfg_data = '0;
        m_floor = 16'd1; m_base = 32'd0;
        m_model_en = 1; m_null_en = 1; m_sq_en = 1; m_pe_en = 1; m_dv_en = 1;
        a_sq_model = 0; a_sq_null = 0; a_pe_model = 0; a_pe_null = 0;
        a_dv_model = 0; a_dv_null = 0; a_lin = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty document against a 1-LSB floor: only the Pearson terms move
        zero_res = '0;
        floor_res = '0;
        floor_res.pe_model = 63'd256;
        floor_res.pe_null  = 63'd256;

        r = row_doc(0, 0, 0, 1); r.typed = 1; r.res = floor_res; rows.push_back(r);
        rows.push_back(row_doc(1, 1, 32'h8000_0000, 0));
        rows.push_back(row_doc(20'hFFFFF, 24'hFFFFFF, 32'hFFFF_FFFF, 1));
        rows.push_back(row_doc(0, 24'hFFFFFF, 32'h8000_0000, 1));
        rows.push_back(row_reg(wda_pkg::CFG_FLOOR_EPS, 0));
        r = row_doc(0, 0, 0, 1); r.typed = 1; r.res = floor_res; rows.push_back(r);
        rows.push_back(row_reg(wda_pkg::CFG_FLOOR_EPS, 32'hFFFF));
        rows.push_back(row_doc(5, 1000, 32'd12345678, 1));
        rows.push_back(row_reg(wda_pkg::CFG_BASE_PROB, 32'h8000_0000));
        rows.push_back(row_doc(3, 4, 1, 0));
        rows.push_back(row_reg(wda_pkg::CFG_DEV_EN, 0));
        rows.push_back(row_doc(7, 100, 32'h4000_0000, 1));
        rows.push_back(row_reg(wda_pkg::CFG_DEV_EN, 1));
        rows.push_back(row_reg(wda_pkg::CFG_SQ_EN, 0));
        rows.push_back(row_reg(wda_pkg::CFG_PE_EN, 0));
        rows.push_back(row_doc(2, 10, 32'h8000_0000, 1));
        rows.push_back(row_reg(wda_pkg::CFG_MODEL_EN, 0));
        rows.push_back(row_reg(wda_pkg::CFG_NULL_EN, 0));
        r = row_doc(9, 50, 32'h1000_0000, 1); r.typed = 1; r.res = zero_res;
        rows.push_back(r);
        rows.push_back(row_reg(CFG_UNUSED, 32'hFFFF_FFFF));
        rows.push_back(row_reg(wda_pkg::CFG_MODEL_EN, 1));
        rows.push_back(row_reg(wda_pkg::CFG_NULL_EN, 1));
        rows.push_back(row_reg(wda_pkg::CFG_SQ_EN, 1));
        rows.push_back(row_reg(wda_pkg::CFG_PE_EN, 1));
        rows.push_back(row_reg(wda_pkg::CFG_BASE_PROB, 32'hFFFF_FFFF));
        rows.push_back(row_doc(20'hFFFFF, 24'h000001, 32'hFFFF_FFFF, 1));

        foreach (rows[i]) begin
            if (rows[i].kind == ROW_CFG) begin
                drain();
                write_reg(rows[i].idx, rows[i].val);
            end else begin
                sender_gap();
                send_doc(rows[i].n, rows[i].len, rows[i].p, rows[i].last,
                         rows[i].typed, rows[i].res);
            end
        end

        total = N_PHASES * PHASE_ITEMS;
        for (int ph = 0; ph < N_PHASES; ph++) begin
            drain();
            case (ph % 4)
                0:       write_reg(wda_pkg::CFG_FLOOR_EPS, 32'd0);
                1:       write_reg(wda_pkg::CFG_FLOOR_EPS, 32'hFFFF);
                default: write_reg(wda_pkg::CFG_FLOOR_EPS, $urandom_range(0, 16'hFFFF));
            endcase
            case (ph % 4)
                0:       write_reg(wda_pkg::CFG_BASE_PROB, 32'h8000_0000);
                1:       write_reg(wda_pkg::CFG_BASE_PROB, 32'd0);
                2:       write_reg(wda_pkg::CFG_BASE_PROB, 32'hFFFF_FFFF);
                default: write_reg(wda_pkg::CFG_BASE_PROB,
                                   $urandom_range(0, 32'h0400_0000));
            endcase
            write_reg(wda_pkg::CFG_MODEL_EN, ph == 0 || $urandom_range(0, 3) != 0);
            write_reg(wda_pkg::CFG_NULL_EN,  ph == 0 || $urandom_range(0, 3) != 0);
            write_reg(wda_pkg::CFG_SQ_EN,    ph == 0 || $urandom_range(0, 3) != 0);
            write_reg(wda_pkg::CFG_PE_EN,    ph == 0 || $urandom_range(0, 3) != 0);
            write_reg(wda_pkg::CFG_DEV_EN,   ph == 0 || $urandom_range(0, 3) != 0);

            left = PHASE_ITEMS;
            while (left > 0) begin
                int run_len;
                run_len = $urandom_range(1, 12);
                if (run_len > left) run_len = left;
                for (int k = 0; k < run_len; k++) begin
                    logic [23:0] len;
                    total--;
                    quiet = (total < QUIET_ITEMS);
                    if (!quiet && $urandom_range(0, 60) == 0) drain();
                    sender_gap();
                    len = ($urandom_range(0, 5) == 0) ? 24'($urandom)
                                                      : 24'($urandom_range(0, 5000));
                    send_doc(rand_count(), len, rand_prob(), k == run_len - 1,
                             1'b0, zero_res);
                end
                left -= run_len;
            end
        end

        i_s_tvalid <= 1'b0;
        while (pending_indices.size() > 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
